// ===== rtl/core/sha1_pkg.sv =====
package sha1_pkg;

    localparam int NUM_WORDS = 5;
    localparam int BLK_WORDS = 16;
    localparam int ROUNDS    = 80;

    typedef logic [31:0] t_word;
    typedef t_word [NUM_WORDS-1:0] t_wv;
    typedef t_word [BLK_WORDS-1:0] t_line;

    localparam t_wv H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                              32'hEFCDAB89, 32'h67452301};

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
    localparam logic [2:0] LAST_IDX   = 3'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD_FIRST,
        ST_PAD_FILL,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_OUT
    } t_state;

    function automatic t_word rotl(input t_word x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

endpackage

// ===== rtl/core/sha1_round.sv =====
module sha1_round (
    input  logic [6:0]    i_round,
    input  sha1_pkg::t_wv i_wv,
    input  sha1_pkg::t_word i_w,
    output sha1_pkg::t_wv o_wv
);
    import sha1_pkg::*;

    t_word f;
    t_word k;
    t_word b, c, d;

    assign b = i_wv[1];
    assign c = i_wv[2];
    assign d = i_wv[3];

    always_comb begin
        case (i_round) inside
            [7'd0:7'd19]: begin
                f = (b & c) | (~b & d);
                k = K_0;
            end
            [7'd20:7'd39]: begin
                f = b ^ c ^ d;
                k = K_1;
            end
            [7'd40:7'd59]: begin
                f = (b & c) | (b & d) | (c & d);
                k = K_2;
            end
            default: begin
                f = b ^ c ^ d;
                k = K_3;
            end
        endcase
    end

    always_comb begin
        o_wv[0] = rotl(i_wv[0], 5) + f + i_wv[4] + k + i_w;
        o_wv[1] = i_wv[0];
        o_wv[2] = rotl(b, 30);
        o_wv[3] = c;
        o_wv[4] = d;
    end

endmodule

// ===== rtl/core/sha1_message_digest.sv =====
// SHA-1 digest of a byte stream, one message byte per input item (tuser flags
// that tdata holds a byte, tlast ends the message). The item that completes a
// 64-byte block holds the input off for the 80 rounds through the single
// shared round unit, one per cycle, then the add into the chaining words. The
// final item triggers padding, pushed into the schedule line one word a
// cycle (with one idle step just before the two length words), followed by
// one or two such compressions; the five digest words then leave most
// significant first, one per accepted output item, and the block is ready
// for the next message.
module sha1_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic [0:0]  i_s_axis_tuser,   // byte_present
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // digest_word
    output logic [2:0]  o_m_axis_tuser,   // word_index
    output logic        o_m_axis_tlast    // last_word
);
    import sha1_pkg::*;

    t_state      r_state, n_state;
    t_state      r_ret;
    t_state      ret_sel;
    t_wv         r_h;
    t_wv         r_wv;
    t_wv         round_wv;
    t_line       r_line, n_line;
    logic [6:0]  r_round;
    logic [23:0] r_acc;
    logic [60:0] r_cnt;
    logic [3:0]  r_wcnt;
    logic [2:0]  r_oidx;

    logic        s_acc;
    logic        m_acc;
    logic        byte_in;
    logic        push;
    logic        full;
    t_word       push_word;
    t_word       pad_word;
    t_word       expand;

    assign s_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc   = o_m_axis_tvalid && i_m_axis_tready;
    assign byte_in = s_acc && i_s_axis_tuser[0];

    // schedule line: r_line[0] is the word used by the current round
    assign expand = rotl(r_line[13] ^ r_line[8] ^ r_line[2] ^ r_line[0], 1);

    sha1_round u_round (
        .i_round (r_round),
        .i_wv    (r_wv),
        .i_w     (r_line[0]),
        .o_wv    (round_wv)
    );

    // 0x80 lands right after the bytes still waiting in the accumulator
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'h0};
            2'd1:    pad_word = {r_acc[7:0], PAD_BYTE, 16'h0};
            2'd2:    pad_word = {r_acc[15:0], PAD_BYTE, 8'h0};
            default: pad_word = {r_acc, PAD_BYTE};
        endcase
    end

    // word pushes into the schedule line and where to go after a compression
    always_comb begin
        push      = 1'b0;
        push_word = '0;
        ret_sel   = r_ret;
        case (r_state)
            ST_IDLE: begin
                push      = byte_in && (r_cnt[1:0] == 2'd3);
                push_word = {r_acc, i_s_axis_tdata};
                ret_sel   = i_s_axis_tlast ? ST_PAD_FIRST : ST_IDLE;
            end
            ST_PAD_FIRST: begin
                push      = 1'b1;
                push_word = pad_word;
                ret_sel   = ST_PAD_FILL;
            end
            ST_PAD_FILL: begin
                push    = (r_wcnt != 4'd14);
                ret_sel = ST_PAD_FILL;
            end
            ST_LEN_HI: begin
                push      = 1'b1;
                push_word = r_cnt[60:29];
            end
            ST_LEN_LO: begin
                push      = 1'b1;
                push_word = {r_cnt[28:0], 3'b000};
                ret_sel   = ST_OUT;
            end
            default: begin
                push = 1'b0;
            end
        endcase
        full = push && (r_wcnt == 4'd15);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    if (full)
                        n_state = ST_ROUND;
                    else if (i_s_axis_tlast)
                        n_state = ST_PAD_FIRST;
                end
            end
            ST_ROUND: begin
                if (r_round == LAST_ROUND)
                    n_state = ST_ADD;
            end
            ST_ADD:       n_state = r_ret;
            ST_PAD_FIRST: n_state = full ? ST_ROUND : ST_PAD_FILL;
            ST_PAD_FILL: begin
                if (r_wcnt == 4'd14)
                    n_state = ST_LEN_HI;
                else if (full)
                    n_state = ST_ROUND;
            end
            ST_LEN_HI:    n_state = ST_LEN_LO;
            ST_LEN_LO:    n_state = ST_ROUND;
            ST_OUT: begin
                if (m_acc && r_oidx == LAST_IDX)
                    n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        o_m_axis_tvalid = (r_state == ST_OUT);
        o_m_axis_tdata  = r_h[r_oidx];
        o_m_axis_tuser  = r_oidx;
        o_m_axis_tlast  = (r_oidx == LAST_IDX);
    end

    always_comb begin
        n_line = r_line;
        if (r_state == ST_ROUND)
            n_line = {expand, r_line[BLK_WORDS-1:1]};
        else if (push)
            n_line = {push_word, r_line[BLK_WORDS-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_h     <= H_INIT;
            r_cnt   <= '0;
            r_wcnt  <= '0;
            r_round <= '0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            if (full)
                r_ret <= ret_sel;
            if (push)
                r_wcnt <= r_wcnt + 4'd1;
            if (byte_in)
                r_cnt <= r_cnt + 61'd1;
            if (r_state == ST_ROUND)
                r_round <= (r_round == LAST_ROUND) ? 7'd0 : r_round + 7'd1;
            if (r_state == ST_ADD) begin
                for (int i = 0; i < NUM_WORDS; i++)
                    r_h[i] <= r_h[i] + r_wv[i];
            end
            if (m_acc) begin
                if (r_oidx == LAST_IDX) begin
                    r_oidx <= '0;
                    r_h    <= H_INIT;
                    r_cnt  <= '0;
                    r_wcnt <= '0;
                end else begin
                    r_oidx <= r_oidx + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_line <= n_line;
        if (byte_in)
            r_acc <= {r_acc[15:0], i_s_axis_tdata};
        if (full)
            r_wv <= r_h;
        else if (r_state == ST_ROUND)
            r_wv <= round_wv;
    end

    a_ready_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid)
        else $error("input ready while digest output is valid");

    a_round_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_ROUND) |-> (r_round == 7'd0))
        else $error("round counter nonzero outside compression");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= LAST_ROUND)
        else $error("round counter out of range");

    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_acc && o_m_axis_tlast) |=> (o_s_axis_tready && r_cnt == 61'd0))
        else $error("block not cleared after final digest word");

    a_full_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_ROUND && n_state == ST_ROUND) |-> full)
        else $error("compression started without a full block");

endmodule
